// ===== src/ipf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipf_pkg
// Shared types and constants of the IPv6 prefix packet filter.
// ----------------------------------------------------------------------------
package ipf_pkg;

    localparam int FULL_LEN   = 128;
    localparam int HALF_LEN   = 64;
    localparam logic [7:0] MCAST_BYTE = 8'hff;

    localparam logic [1:0] CMD_CLASSIFY    = 2'd0;
    localparam logic [1:0] CMD_WRITE_PROT  = 2'd1;
    localparam logic [1:0] CMD_WRITE_ALLOW = 2'd2;

    localparam logic [2:0] RSN_NOT_IP6 = 3'd0;
    localparam logic [2:0] RSN_LOCAL   = 3'd1;
    localparam logic [2:0] RSN_PROT_IF = 3'd2;
    localparam logic [2:0] RSN_SPOOF   = 3'd3;
    localparam logic [2:0] RSN_MCAST   = 3'd4;
    localparam logic [2:0] RSN_ALLOWED = 3'd5;
    localparam logic [2:0] RSN_DEFAULT = 3'd6;
    localparam logic [2:0] RSN_WRITE   = 3'd7;

    typedef struct packed {
        logic [1:0]  command;
        logic        is_ipv6;
        logic        header_complete;
        logic [15:0] ingress_if;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [5:0]  entry_slot;
        logic [7:0]  entry_len;
        logic        entry_valid;
    } item_t;

    typedef struct packed {
        logic        verdict;
        logic [2:0]  decision_reason;
        logic [63:0] passed_total;
        logic [63:0] dropped_total;
    } result_t;

    typedef struct packed {
        logic [1:0]  command;
        logic        early;
        logic [2:0]  reason;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [5:0]  slot;
        logic [7:0]  len;
        logic        entry_valid;
    } job_t;

endpackage
`default_nettype wire

// ===== src/ipf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipf_front
// Accept beats, hold the interface register and resolve the early rules.
// ----------------------------------------------------------------------------
module ipf_front
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire ipf_pkg::item_t item,
    input  wire logic           cfg_we,
    input  wire logic [15:0]    cfg_data,
    input  wire logic           q_full,
    output logic                busy,
    output logic                push,
    output ipf_pkg::job_t       job
);

    logic [15:0] prot_if_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prot_if_reg <= '0;
        end
        else if (cfg_we)
        begin
            prot_if_reg <= cfg_data;
        end
    end

    assign busy = q_full;
    assign push = start && !q_full;

    always_comb
    begin
        job.command     = item.command;
        job.src_hi      = item.src_hi;
        job.src_lo      = item.src_lo;
        job.dst_hi      = item.dst_hi;
        job.dst_lo      = item.dst_lo;
        job.slot        = item.entry_slot;
        job.len         = (item.entry_len > 8'(ipf_pkg::FULL_LEN)) ?
                          8'(ipf_pkg::FULL_LEN) : item.entry_len;
        job.entry_valid = item.entry_valid;
        job.early       = 1'b1;
        job.reason      = ipf_pkg::RSN_NOT_IP6;
        if (!item.is_ipv6 || !item.header_complete)
        begin
            job.reason = ipf_pkg::RSN_NOT_IP6;
        end
        else if (item.ingress_if == '0)
        begin
            job.reason = ipf_pkg::RSN_LOCAL;
        end
        else if (prot_if_reg != '0 && item.ingress_if == prot_if_reg)
        begin
            job.reason = ipf_pkg::RSN_PROT_IF;
        end
        else
        begin
            job.early = 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== src/ipf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipf_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module ipf_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ipf_pkg::job_t push_job,
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output ipf_pkg::job_t      head
);

    ipf_pkg::job_t slot_reg [2];
    logic          wptr_reg;
    logic          rptr_reg;
    logic [1:0]    count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

// ===== src/ipf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipf_back
// Execute jobs: table writes, prefix table sweep, verdict and counters.
// ----------------------------------------------------------------------------
module ipf_back
#(
    parameter int DEPTH = 64
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire ipf_pkg::job_t head,
    output logic               pop,
    output logic               done,
    output ipf_pkg::result_t   result
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW = 64 + 64 + 8;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [EW-1:0] prot_mem  [DEPTH];
    logic [EW-1:0] allow_mem [DEPTH];
    logic [EW-1:0] prot_rd_reg;
    logic [EW-1:0] allow_rd_reg;

    logic [1:0]       state_reg, state_next;
    ipf_pkg::job_t    job_reg, job_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    cmp_idx_reg;
    logic             cmp_v_reg, cmp_v_next;
    logic             prot_hit_reg, prot_hit_next;
    logic             allow_hit_reg, allow_hit_next;
    logic [DEPTH-1:0] prot_vld_reg, prot_vld_next;
    logic [DEPTH-1:0] allow_vld_reg, allow_vld_next;
    logic [63:0]      pass_reg, pass_next;
    logic [63:0]      drop_reg, drop_next;
    logic             done_reg, done_next;
    ipf_pkg::result_t result_reg, result_next;

    logic             prot_we, allow_we;
    logic [IW-1:0]    waddr;
    logic [EW-1:0]    wdata;
    logic             slot_ok;
    logic             prot_match, allow_match;

    function automatic logic covers(input logic [EW-1:0] ent,
                                    input logic [63:0] hi,
                                    input logic [63:0] lo);
        logic [7:0]  len;
        logic [63:0] mh;
        logic [63:0] ml;
        begin
            len = ent[7:0];
            mh  = (len >= 8'(ipf_pkg::HALF_LEN)) ? '1 : ~({64{1'b1}} >> len);
            ml  = (len <= 8'(ipf_pkg::HALF_LEN)) ? '0 :
                  ~({64{1'b1}} >> (len - 8'(ipf_pkg::HALF_LEN)));
            covers = (((hi ^ ent[EW-1:72]) & mh) == '0) &&
                     (((lo ^ ent[71:8]) & ml) == '0);
        end
    endfunction

    assign slot_ok = (32'(head.slot) < DEPTH);
    assign waddr   = head.slot[IW-1:0];
    assign wdata   = {head.src_hi, head.src_lo, head.len};

    assign prot_match  = cmp_v_reg && prot_vld_reg[cmp_idx_reg] &&
                         covers(prot_rd_reg, job_reg.src_hi, job_reg.src_lo);
    assign allow_match = cmp_v_reg && allow_vld_reg[cmp_idx_reg] &&
                         covers(allow_rd_reg, job_reg.dst_hi, job_reg.dst_lo);

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        cmp_v_next     = 1'b0;
        prot_hit_next  = prot_hit_reg || prot_match;
        allow_hit_next = allow_hit_reg || allow_match;
        prot_vld_next  = prot_vld_reg;
        allow_vld_next = allow_vld_reg;
        pass_next      = pass_reg;
        drop_next      = drop_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        pop            = 1'b0;
        prot_we        = 1'b0;
        allow_we       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    job_next = head;
                    if (head.command != ipf_pkg::CMD_CLASSIFY)
                    begin
                        if (slot_ok && head.command == ipf_pkg::CMD_WRITE_PROT)
                        begin
                            prot_we = 1'b1;
                            prot_vld_next[waddr] = head.entry_valid;
                        end
                        if (slot_ok && head.command == ipf_pkg::CMD_WRITE_ALLOW)
                        begin
                            allow_we = 1'b1;
                            allow_vld_next[waddr] = head.entry_valid;
                        end
                        done_next   = 1'b1;
                        result_next = '{1'b0, ipf_pkg::RSN_WRITE, pass_reg, drop_reg};
                    end
                    else if (head.early)
                    begin
                        done_next = 1'b1;
                        if (head.reason == ipf_pkg::RSN_PROT_IF)
                        begin
                            drop_next = drop_reg + 64'd1;
                        end
                        result_next = '{head.reason == ipf_pkg::RSN_PROT_IF,
                                        head.reason, pass_reg, drop_next};
                    end
                    else
                    begin
                        state_next     = ST_SCAN;
                        idx_next       = '0;
                        prot_hit_next  = 1'b0;
                        allow_hit_next = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                cmp_v_next = 1'b1;
                if (idx_reg == IW'(DEPTH - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (prot_hit_reg)
                begin
                    drop_next   = drop_reg + 64'd1;
                    result_next = '{1'b1, ipf_pkg::RSN_SPOOF, pass_reg, drop_next};
                end
                else if (job_reg.dst_hi[63:56] == ipf_pkg::MCAST_BYTE)
                begin
                    pass_next   = pass_reg + 64'd1;
                    result_next = '{1'b0, ipf_pkg::RSN_MCAST, pass_next, drop_reg};
                end
                else if (allow_hit_reg)
                begin
                    pass_next   = pass_reg + 64'd1;
                    result_next = '{1'b0, ipf_pkg::RSN_ALLOWED, pass_next, drop_reg};
                end
                else
                begin
                    drop_next   = drop_reg + 64'd1;
                    result_next = '{1'b1, ipf_pkg::RSN_DEFAULT, pass_reg, drop_next};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (prot_we)
        begin
            prot_mem[waddr] <= wdata;
        end
        if (allow_we)
        begin
            allow_mem[waddr] <= wdata;
        end
        prot_rd_reg  <= prot_mem[idx_reg];
        allow_rd_reg <= allow_mem[idx_reg];
        cmp_idx_reg  <= idx_reg;
        job_reg      <= job_next;
        idx_reg      <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_v_reg     <= 1'b0;
            prot_hit_reg  <= 1'b0;
            allow_hit_reg <= 1'b0;
            prot_vld_reg  <= '0;
            allow_vld_reg <= '0;
            pass_reg      <= '0;
            drop_reg      <= '0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_v_reg     <= cmp_v_next;
            prot_hit_reg  <= prot_hit_next;
            allow_hit_reg <= allow_hit_next;
            prot_vld_reg  <= prot_vld_next;
            allow_vld_reg <= allow_vld_next;
            pass_reg      <= pass_next;
            drop_reg      <= drop_next;
            done_reg      <= done_next;
            result_reg    <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== src/ipv6_prefix_packet_filter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_prefix_packet_filter_unit
// IPv6 header filter with protected-source and allowed-destination tables.
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------
//   input    | start / busy     | item   (ipf_pkg::item_t)
//   result   | done (strobe)    | result (ipf_pkg::result_t)
//   config   | cfg_we           | cfg_data (16 bits)
//
// Writes and early-rule packets (not IPv6, local, protected interface) are registered
// in a queue slot and then in the done register; a packet that needs the tables sweeps
// both in parallel, one entry per cycle from the table memories.
// A two-beat queue lets start be taken while the back end works.
// Reset clears valid bits, counters and the interface register; no clearing pass.
// The receiver cannot stall; each result is valid for the one done cycle.
// ----------------------------------------------------------------------------
module ipv6_prefix_packet_filter_unit
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire ipf_pkg::item_t   item,
    input  wire logic             cfg_we,
    input  wire logic [15:0]      cfg_data,
    output logic                  done,
    output ipf_pkg::result_t      result
);

    localparam int DEPTH = (TABLE_ENTRIES < 64) ? TABLE_ENTRIES : 64;

    logic          q_full;
    logic          q_empty;
    logic          push;
    logic          pop;
    ipf_pkg::job_t push_job;
    ipf_pkg::job_t head;

    ipf_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .busy     (busy),
        .push     (push),
        .job      (push_job)
    );

    ipf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    ipf_back #(.DEPTH(DEPTH)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (head),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

    a_write_pass: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.decision_reason == ipf_pkg::RSN_WRITE |-> !result.verdict)
        else $error("write beat carries a drop verdict");

    a_write_counters: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.decision_reason == ipf_pkg::RSN_WRITE |->
        result.passed_total == $past(result.passed_total) &&
        result.dropped_total == $past(result.dropped_total))
        else $error("write beat changed a counter");

    a_drop_reason: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.verdict |->
        result.decision_reason == ipf_pkg::RSN_PROT_IF ||
        result.decision_reason == ipf_pkg::RSN_SPOOF ||
        result.decision_reason == ipf_pkg::RSN_DEFAULT)
        else $error("drop verdict with a pass reason");

endmodule
`default_nettype wire
